@@ rtl/core/pzb_pkg.sv @@
// Package for the perspective z-buffer depth test: shared types, codes and constants.
// It depends on nothing; every other file of the block but pzb_ram imports it.
package pzb_pkg;

    localparam int unsigned SCREEN_SIZE_DEF = 512;
    localparam logic [31:0] FOCAL_RESET     = 32'd42162586;
    localparam logic [8:0]  CENTER_RESET    = 9'd256;
    localparam logic [31:0] DEPTH_MAX       = 32'hFFFF_FFFF;
    localparam int unsigned DIV_STEPS       = 64;
    localparam int unsigned CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_CENTER = 2'd1;

    typedef enum logic [1:0] {
        OUT_DRAWN      = 2'd0,
        OUT_OFF_SCREEN = 2'd1,
        OUT_HIDDEN     = 2'd2,
        OUT_BEHIND_EYE = 2'd3
    } outcome_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_POST,
        ST_ADDR,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/core/pzb_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module pzb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/core/pzb_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the projection quotient.
// Depends on pzb_pkg.
module pzb_divider
    import pzb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [46:0] divisor,
    output logic [63:0] quotient,
    output logic        rem_nonzero,
    output div_status_t status
);

    logic [63:0] quo_reg;
    logic [46:0] rem_reg;
    logic [46:0] div_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [47:0] trial;
    logic        qbit;
    logic [46:0] rem_new;

    always_comb
    begin
        trial   = {rem_reg, quo_reg[63]};
        qbit    = (trial >= {1'b0, div_reg});
        rem_new = qbit ? 47'(trial - {1'b0, div_reg}) : trial[46:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[62:0], qbit};
            rem_reg <= rem_new;
        end
    end

    assign quotient    = quo_reg;
    assign rem_nonzero = (rem_reg != '0);
    assign status      = '{busy: busy_reg, done: done_reg};

endmodule

@@ rtl/core/perspective_zbuffer_depth_test.sv @@
// Top level of the perspective z-buffer depth test.
// Depends on pzb_pkg, pzb_ram and pzb_divider.
//
// Usage. Points enter on the input channel (in_valid/in_ready) as eye-space
// x, y, z in signed Q16.16 with 8-bit red, green and blue. Each transfer
// yields exactly one result on the output channel (out_valid/out_ready):
// drawn, off screen, hidden or behind the eye. Pixel and colour fields are
// zero unless drawn. The block works on one point at a time. A point behind
// the eye skips the arithmetic and goes straight to the hand-over into the
// output register. A point that reaches the depth test goes, for each axis,
// through a multiply, a division on the shared bit-serial divider and a step
// that applies the sign and the centre, followed by a depth read, a compare
// and write back (skipped when off screen), and a hand-over to the output
// register, after which the input is ready again in the next cycle.
// The depth store is one single-port RAM of SCREEN_SIZE squared entries.
// After reset a clearing pass writes maximum depth to every entry, one per
// cycle; no input is accepted meanwhile, though configuration writes are
// taken. Results sit in an output register; a new point may be accepted
// while a result waits, but the next result is held back until the receiver
// takes the pending one, so a stalled receiver simply stalls the block.
module perspective_zbuffer_depth_test
    import pzb_pkg::*;
#(
    parameter int unsigned SCREEN_SIZE = SCREEN_SIZE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          eye_x,
    input  logic [31:0]          eye_y,
    input  logic [31:0]          eye_z,
    input  logic [7:0]           color_red,
    input  logic [7:0]           color_green,
    input  logic [7:0]           color_blue,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           outcome,
    output logic [8:0]           pixel_x,
    output logic [8:0]           pixel_y,
    output logic [7:0]           out_red,
    output logic [7:0]           out_green,
    output logic [7:0]           out_blue
);

    localparam int unsigned DEPTH   = SCREEN_SIZE * SCREEN_SIZE;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned COORD_W = $clog2(SCREEN_SIZE);

    state_t state_reg, state_next;

    logic [31:0] focal_reg;
    logic [8:0]  center_reg;

    logic [31:0] x_reg, y_reg, z_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic        axis_reg;
    logic [63:0] prod_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic        px_ok_reg, py_ok_reg;
    logic [ADDR_W-1:0]  addr_reg, clr_cnt_reg;
    outcome_t    res_reg;

    logic        out_valid_reg;
    logic [1:0]  outcome_reg;
    logic [8:0]  pixel_x_reg, pixel_y_reg;
    logic [7:0]  red_out_reg, green_out_reg, blue_out_reg;

    logic [31:0] coord_sel;
    logic [31:0] coord_mag;
    logic        behind;
    logic        accept;
    logic        out_free;

    logic        div_start;
    logic [63:0] div_quo;
    logic        div_rnz;
    div_status_t div_stat;

    logic signed [65:0] floor_val;
    logic signed [65:0] coord_sum;
    logic               coord_ok;

    logic [ADDR_W-1:0] lookup_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_rdata;
    logic              nearer;

    // Configuration registers; writes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= FOCAL_RESET;
            center_reg <= CENTER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FOCAL_SCALE:   focal_reg  <= cfg_data;
                CFG_SCREEN_CENTER: center_reg <= cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign behind   = eye_z[31] || (eye_z == 32'd0);
    assign out_free = !out_valid_reg || out_ready;

    // Magnitude of the coordinate under work; the sign is reapplied after division.
    assign coord_sel = axis_reg ? y_reg : x_reg;
    assign coord_mag = coord_sel[31] ? 32'(-coord_sel) : coord_sel;

    assign div_start = (state_reg == ST_DIV_START);

    pzb_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend    (prod_reg),
        .divisor     ({z_reg[30:0], 16'd0}),
        .quotient    (div_quo),
        .rem_nonzero (div_rnz),
        .status      (div_stat)
    );

    // Floor of a negative quotient is one lower when the division was inexact.
    always_comb
    begin
        floor_val = coord_sel[31] ? (-$signed({2'b00, div_quo}) - $signed(66'(div_rnz)))
                                  : $signed({2'b00, div_quo});
        coord_sum = floor_val + $signed(66'(center_reg));
        coord_ok  = !coord_sum[65] && (coord_sum < $signed(66'(SCREEN_SIZE)));
    end

    assign lookup_addr = ADDR_W'(py_reg * SCREEN_SIZE) + ADDR_W'(px_reg);
    assign nearer      = (ram_rdata > z_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = lookup_addr;
        ram_wdata = z_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = DEPTH_MAX;
            end
            ST_CMP:
            begin
                ram_we   = nearer;
                ram_addr = addr_reg;
            end
            default: ;
        endcase
    end

    pzb_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_depth (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:     if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = behind ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:       state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_stat.done) state_next = ST_POST;
            ST_POST:      state_next = axis_reg ? ST_ADDR : ST_MUL;
            ST_ADDR:      state_next = (px_ok_reg && py_ok_reg) ? ST_CMP : ST_DONE;
            ST_CMP:       state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x_reg     <= eye_x;
                y_reg     <= eye_y;
                z_reg     <= eye_z;
                red_reg   <= color_red;
                green_reg <= color_green;
                blue_reg  <= color_blue;
                axis_reg  <= 1'b0;
                res_reg   <= OUT_BEHIND_EYE;
            end
            ST_MUL:
            begin
                prod_reg <= 64'(coord_mag) * 64'(focal_reg);
            end
            ST_POST:
            begin
                if (axis_reg)
                begin
                    py_reg    <= coord_sum[COORD_W-1:0];
                    py_ok_reg <= coord_ok;
                end
                else
                begin
                    px_reg    <= coord_sum[COORD_W-1:0];
                    px_ok_reg <= coord_ok;
                end
                axis_reg <= 1'b1;
            end
            ST_ADDR:
            begin
                addr_reg <= lookup_addr;
                res_reg  <= OUT_OFF_SCREEN;
            end
            ST_CMP:
            begin
                res_reg <= nearer ? OUT_DRAWN : OUT_HIDDEN;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    outcome_reg <= res_reg;
                    if (res_reg == OUT_DRAWN)
                    begin
                        pixel_x_reg   <= 9'(px_reg);
                        pixel_y_reg   <= 9'(py_reg);
                        red_out_reg   <= red_reg;
                        green_out_reg <= green_reg;
                        blue_out_reg  <= blue_reg;
                    end
                    else
                    begin
                        pixel_x_reg   <= '0;
                        pixel_y_reg   <= '0;
                        red_out_reg   <= '0;
                        green_out_reg <= '0;
                        blue_out_reg  <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign outcome   = outcome_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign out_red   = red_out_reg;
    assign out_green = green_out_reg;
    assign out_blue  = blue_out_reg;

endmodule

@@ rtl/core/pzb_checker.sv @@
// Port-level checker for the perspective z-buffer depth test, bound to the top level.
// Depends on pzb_pkg and perspective_zbuffer_depth_test.
module pzb_checker
    import pzb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] outcome,
    input logic [8:0] pixel_x,
    input logic [8:0] pixel_y,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(outcome) && $stable(pixel_x))
        else $error("stalled result changed");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome != OUT_DRAWN) |-> (pixel_x == 9'd0) && (pixel_y == 9'd0)
        && (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0))
        else $error("undrawn result carries pixel data");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second point accepted while one is at work");

endmodule

bind perspective_zbuffer_depth_test pzb_checker u_pzb_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for the perspective z-buffer depth test block.
// Depends on pzb_pkg and the perspective_zbuffer_depth_test RTL; a directed table is
// followed by constrained-by-hand random points, all checked against a built-in predictor.
module testbench
    import pzb_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SCREEN = SCREEN_SIZE_DEF;

    // One expected or observed result.
    typedef struct {
        outcome_t   oc;
        logic [8:0] px;
        logic [8:0] py;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_result_t;

    // One row of the directed table. A row may carry a typed outcome that the
    // predictor must agree with; otherwise the predictor alone decides.
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        bit          typed;
        outcome_t    oc;
    } point_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [31:0]          eye_x;
    logic [31:0]          eye_y;
    logic [31:0]          eye_z;
    logic [7:0]           color_red;
    logic [7:0]           color_green;
    logic [7:0]           color_blue;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           outcome;
    logic [8:0]           pixel_x;
    logic [8:0]           pixel_y;
    logic [7:0]           out_red;
    logic [7:0]           out_green;
    logic [7:0]           out_blue;

    perspective_zbuffer_depth_test dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .eye_x       (eye_x),
        .eye_y       (eye_y),
        .eye_z       (eye_z),
        .color_red   (color_red),
        .color_green (color_green),
        .color_blue  (color_blue),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .outcome     (outcome),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue)
    );

    // The predictor's own copy of the configuration and of the depth store.
    // The depth store is sparse: an entry never written still holds maximum depth.
    logic [31:0]   pred_focal;
    logic [8:0]    pred_center;
    logic [31:0]   pred_depth [int];
    pixel_result_t pending_pixels [$];

    int  mismatches;
    bit  failed;
    bit  quiet;      // When set, neither side idles.
    bit  hold_req;   // Asks the receiver for one long hold-off.

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // A watchdog whose limit leaves ample margin for the clearing pass after reset and the whole run.
    initial
    begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

    // Floor division for a strictly positive divisor.
    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if (num < 0 && (num % den) != 0)
            q = q - 1;
        return q;
    endfunction

    // Projects one raw coordinate onto the screen with the current settings.
    function automatic longint project_axis(logic [31:0] coord, logic [31:0] z);
        longint num;
        longint den;
        num = longint'($signed(coord)) * longint'({32'd0, pred_focal});
        den = longint'($signed(z)) * 64'sd65536;
        return floor_div(num, den) + longint'({55'd0, pred_center});
    endfunction

    // Works out the result of one point and updates the predicted depth store.
    function automatic pixel_result_t predict_pixel(point_row_t p);
        pixel_result_t res;
        longint        px;
        longint        py;
        int            idx;
        logic [31:0]   stored;
        res = '{oc: OUT_DRAWN, px: '0, py: '0, r: '0, g: '0, b: '0};
        if ($signed(p.z) <= 0)
        begin
            res.oc = OUT_BEHIND_EYE;
            return res;
        end
        px = project_axis(p.x, p.z);
        py = project_axis(p.y, p.z);
        if (px < 0 || px >= SCREEN || py < 0 || py >= SCREEN)
        begin
            res.oc = OUT_OFF_SCREEN;
            return res;
        end
        idx    = int'(py) * SCREEN + int'(px);
        stored = pred_depth.exists(idx) ? pred_depth[idx] : DEPTH_MAX;
        if (!(stored > p.z))
        begin
            res.oc = OUT_HIDDEN;
            return res;
        end
        pred_depth[idx] = p.z;
        res.px = px[8:0];
        res.py = py[8:0];
        res.r  = p.r;
        res.g  = p.g;
        res.b  = p.b;
        return res;
    endfunction

    // Records one mismatch; only the first ten are printed.
    task automatic report_mismatch(string what, pixel_result_t exp_res, pixel_result_t act_res);
        failed     = 1'b1;
        mismatches = mismatches + 1;
        if (mismatches <= 10)
            $display({"mismatch (%s): expected oc=%0d x=%0d y=%0d rgb=%0d/%0d/%0d,",
                " got oc=%0d x=%0d y=%0d rgb=%0d/%0d/%0d"},
                what, exp_res.oc, exp_res.px, exp_res.py, exp_res.r, exp_res.g, exp_res.b,
                act_res.oc, act_res.px, act_res.py, act_res.r, act_res.g, act_res.b);
    endtask

    // Offers one point and waits for its transfer. It is always entered just
    // after a rising edge, and it returns just after the edge of the transfer.
    task automatic send_point(point_row_t p);
        pixel_result_t exp_res;
        if (!quiet && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        eye_x       <= p.x;
        eye_y       <= p.y;
        eye_z       <= p.z;
        color_red   <= p.r;
        color_green <= p.g;
        color_blue  <= p.b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        exp_res = predict_pixel(p);
        if (p.typed && exp_res.oc != p.oc)
            report_mismatch("table row", '{oc: p.oc, px: exp_res.px, py: exp_res.py,
                r: exp_res.r, g: exp_res.g, b: exp_res.b}, exp_res);
        pending_pixels.push_back(exp_res);
    endtask

    // Lets every expected result arrive, then a short settling pause.
    task automatic drain_pixels();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes both registers, with junk above the centre's width, and then an
    // index that maps to no register. Only legal while the block is idle.
    task automatic write_settings(logic [31:0] focal, logic [8:0] center);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FOCAL_SCALE;
        cfg_data  <= focal;
        @(posedge clk);
        cfg_index <= CFG_SCREEN_CENTER;
        cfg_data  <= {23'($urandom_range(32'h7F_FFFF, 0)), center};
        @(posedge clk);
        cfg_index <= CFG_IDX_W'(3);
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we     <= 1'b0;
        pred_focal  = focal;
        pred_center = center;
    endtask

    // Picks a raw eye coordinate that lands about 'off' pixels from the centre
    // at depth z, so that most random points reach the depth test.
    function automatic logic [31:0] aim_coord(int off, logic [31:0] z);
        longint v;
        if (pred_focal == 0)
            return $urandom;
        v = (longint'(off) * longint'($signed(z)) * 64'sd65536) / longint'({32'd0, pred_focal});
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // Builds one random point: mostly aimed on screen, often onto a few shared
    // pixels so that depth collisions happen, with some raw noise mixed in.
    function automatic point_row_t random_point();
        point_row_t p;
        int         offx;
        int         offy;
        p.typed = 1'b0;
        p.oc    = OUT_DRAWN;
        p.r     = 8'($urandom);
        p.g     = 8'($urandom);
        p.b     = 8'($urandom);
        if ($urandom_range(99) < 15)
        begin
            p.x = $urandom;
            p.y = $urandom;
            p.z = ($urandom_range(3) == 0) ? ($urandom | 32'h8000_0000) : $urandom;
            return p;
        end
        p.z = $urandom_range(32'h0010_0000, 1);
        if ($urandom_range(1) == 0)
        begin
            offx = $urandom_range(8, 0) - 4;
            offy = $urandom_range(8, 0) - 4;
        end
        else
        begin
            offx = $urandom_range(600, 0) - 300;
            offy = $urandom_range(600, 0) - 300;
        end
        p.x = aim_coord(offx, p.z);
        p.y = aim_coord(offy, p.z);
        return p;
    endfunction

    // Receiver side: random idling, a quiet stretch, and one long hold-off
    // that lets the block fill up and refuse further input.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (1000) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
        end
    end

    // Result checker: every transfer on the output channel is compared with
    // the oldest expectation, field by field.
    always @(posedge clk)
    begin
        pixel_result_t act_res;
        pixel_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            act_res = '{oc: outcome_t'(outcome), px: pixel_x, py: pixel_y,
                r: out_red, g: out_green, b: out_blue};
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected result", act_res, act_res);
            else
            begin
                exp_res = pending_pixels.pop_front();
                if (act_res.oc !== exp_res.oc || act_res.px !== exp_res.px
                    || act_res.py !== exp_res.py || act_res.r !== exp_res.r
                    || act_res.g !== exp_res.g || act_res.b !== exp_res.b)
                    report_mismatch("result", exp_res, act_res);
            end
        end
    end

    // Stimulus.
    initial
    begin
        point_row_t  table_rows [$];
        logic [31:0] phase_focal  [6];
        logic [8:0]  phase_center [6];
        int          n;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        eye_x       = '0;
        eye_y       = '0;
        eye_z       = '0;
        color_red   = '0;
        color_green = '0;
        color_blue  = '0;
        mismatches  = 0;
        failed      = 1'b0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        pred_focal  = FOCAL_RESET;
        pred_center = CENTER_RESET;

        // Directed table, run with the settings left by reset. Centre point at
        // unit depth is drawn, the same depth again is hidden (equal does not
        // draw), a hair nearer draws again.
        table_rows.push_back('{32'h0, 32'h0, 32'h0001_0000, 8'hFF, 8'h00, 8'h80, 1, OUT_DRAWN});
        table_rows.push_back('{32'h0, 32'h0, 32'h0001_0000, 8'h01, 8'h02, 8'h03, 1, OUT_HIDDEN});
        table_rows.push_back('{32'h0, 32'h0, 32'h0000_FFFF, 8'h00, 8'hFF, 8'h00, 1, OUT_DRAWN});
        table_rows.push_back('{32'h0, 32'h0, 32'h7FFF_FFFF, 8'hAA, 8'h55, 8'hFF, 1, OUT_HIDDEN});
        // Behind the eye: zero, minus one and the most negative depth.
        table_rows.push_back('{32'h0, 32'h0, 32'h0, 8'hFF, 8'hFF, 8'hFF, 1, OUT_BEHIND_EYE});
        table_rows.push_back('{32'h1234, 32'h0, 32'hFFFF_FFFF, 8'h12, 8'h34, 8'h56,
            1, OUT_BEHIND_EYE});
        table_rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 8'h0, 8'h0, 8'h0,
            1, OUT_BEHIND_EYE});
        // Extremes of x and y at unit depth land far off screen.
        table_rows.push_back('{32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 8'h0, 8'h0, 8'h0,
            1, OUT_OFF_SCREEN});
        table_rows.push_back('{32'h8000_0000, 32'h0, 32'h0001_0000, 8'h0, 8'h0, 8'h0,
            1, OUT_OFF_SCREEN});
        table_rows.push_back('{32'h0, 32'h7FFF_FFFF, 32'h0001_0000, 8'h0, 8'h0, 8'h0,
            1, OUT_OFF_SCREEN});
        table_rows.push_back('{32'h0, 32'h8000_0000, 32'h0001_0000, 8'h0, 8'h0, 8'h0,
            1, OUT_OFF_SCREEN});
        // Small negative coordinates floor towards minus infinity.
        table_rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 8'h11, 8'h22, 8'h33,
            0, OUT_DRAWN});
        table_rows.push_back('{32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 8'h44, 8'h55, 8'h66,
            0, OUT_DRAWN});
        // Near the screen edges and at the largest positive depth.
        table_rows.push_back('{32'h0000_6580, 32'h0, 32'h0001_0000, 8'h77, 8'h88, 8'h99,
            0, OUT_DRAWN});
        table_rows.push_back('{32'hFFFF_9A80, 32'h0000_6580, 32'h0001_0000, 8'hFE, 8'h01, 8'h7F,
            0, OUT_DRAWN});
        table_rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hC3, 8'h3C, 8'h5A,
            0, OUT_DRAWN});
        table_rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 8'h0F, 8'hF0, 8'h99,
            0, OUT_DRAWN});

        phase_focal[0] = 32'h0;          phase_center[0] = 9'd256;
        phase_focal[1] = 32'hFFFF_FFFF;  phase_center[1] = 9'd0;
        phase_focal[2] = 32'hFFFF_FFFF;  phase_center[2] = 9'd511;
        phase_focal[3] = FOCAL_RESET;    phase_center[3] = 9'd0;
        phase_focal[4] = FOCAL_RESET;    phase_center[4] = 9'd511;
        phase_focal[5] = $urandom;       phase_center[5] = 9'($urandom);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_point(table_rows[i]);
        drain_pixels();

        // Random phases. The first runs at reset settings and holds a quiet
        // stretch and the long receiver hold-off; each later phase starts
        // only once every result has arrived, so the sender pauses there.
        for (int ph = -1; ph < 6; ph++)
        begin
            if (ph >= 0)
                write_settings(phase_focal[ph], phase_center[ph]);
            else
                write_settings(FOCAL_RESET, CENTER_RESET);
            n = (ph == -1) ? 200 : 115;
            for (int k = 0; k < n; k++)
            begin
                if (ph == -1 && k == 20)
                    quiet = 1'b1;
                if (ph == -1 && k == 80)
                    quiet = 1'b0;
                if (ph == -1 && k == 100)
                    hold_req = 1'b1;
                send_point(random_point());
            end
            drain_pixels();
        end

        repeat (20) @(posedge clk);
        if (!failed && pending_pixels.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ perspective_zbuffer_depth_test.f @@
rtl/core/pzb_pkg.sv
rtl/core/pzb_ram.sv
rtl/core/pzb_divider.sv
rtl/core/perspective_zbuffer_depth_test.sv
rtl/core/pzb_checker.sv
dv/testbench.sv
